### hw/rtl/page_frame_table_claim_top_assert.svh
// Assertion macros for the page frame table claim block.
`ifndef PAGE_FRAME_TABLE_CLAIM_TOP_ASSERT_SVH
`define PAGE_FRAME_TABLE_CLAIM_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PFTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pftc assertion failed");

// Next-cycle implication, disabled in reset.
`define PFTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pftc assertion failed");

`endif

### hw/rtl/pftc_pkg.sv
// Shared types, codes and constants of the page frame table claim block.
package pftc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int PAGE_SHIFT    = 12;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int ADDR_W        = 48;
  localparam int FRAME_W       = ADDR_W - PAGE_SHIFT;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLAIM = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_SIZE      = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] OWN_FREE   = 2'd0;
  localparam logic [1:0] OWN_KERNEL = 2'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        region_usable;
    logic [47:0] range_start;
    logic [47:0] range_end;
    logic [9:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] page_count;
    logic [35:0] frame_number;
    logic [1:0]  owner;
    logic [7:0]  use_count;
    logic        allocated;
  } rsp_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [1:0]         owner;
    logic [7:0]         uses;
    logic               alloc;
  } desc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CLM_CHK,
    S_CLM_CMP,
    S_CLM_SIZE,
    S_CLM_FIN,
    S_RD_OUT,
    S_DONE
  } state_t;

endpackage

### hw/rtl/page_frame_table_claim_top.sv
// Page frame table claim block: descriptor table, add, claim and read sequencer.
// A read returns the addressed entry; an add appends one entry per page of the range; a claim
//   searches the table for the start frame, then claims one page after another.
// Throughput: one transaction at a time; the next start is taken the cycle after done.
// The table's one read port and the shared adder and comparator serialise these steps.
// Reset empties the table (entry count zero); results cannot be stalled.
module page_frame_table_claim_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pftc_pkg::req_t request,
  output logic          done,
  output pftc_pkg::rsp_t result
);

  localparam int AW = pftc_pkg::ADDR_W + 1;
  localparam int PS = pftc_pkg::PAGE_SHIFT;

  pftc_pkg::state_t state, state_next;
  pftc_pkg::req_t   cmd;
  pftc_pkg::desc_t  mem [pftc_pkg::TABLE_ENTRIES];
  pftc_pkg::desc_t  mem_rdata;
  pftc_pkg::desc_t  mem_wdata;
  pftc_pkg::rsp_t   rsp_next;

  logic [pftc_pkg::CNT_W-1:0] entry_total;
  logic [pftc_pkg::CNT_W-1:0] idx;
  logic [pftc_pkg::CNT_W-1:0] claimed;
  logic [AW-1:0]              addr;
  logic [AW-1:0]              addend;
  logic [AW-1:0]              sum;
  logic [AW-1:0]              cmp_a;
  logic [AW-1:0]              cmp_b;
  logic                       cmp_lt;
  logic [pftc_pkg::ADDR_W-1:0] size;
  logic [pftc_pkg::FRAME_W:0] want;
  logic [pftc_pkg::IDX_W-1:0] rd_addr;
  logic [pftc_pkg::IDX_W-1:0] mem_waddr;
  logic                       mem_we;
  logic                       accept;
  logic                       full;
  logic                       idx_end;
  logic                       srch_hit;
  logic                       clm_ok;
  logic                       rsp_load;
  logic                       idx_clr;
  logic                       idx_inc;
  logic                       addr_load;
  logic                       addr_adv;
  logic                       claimed_inc;
  logic                       total_inc;
  logic                       size_load;

  assign accept = start && !busy;

  // shared address adder and comparator
  assign addend = (state == pftc_pkg::S_ADD_CHK) ? AW'((1 << PS) - 1) : AW'(1 << PS);
  assign sum    = addr + addend;
  always_comb begin
    if (state == pftc_pkg::S_ADD_CHK) begin
      cmp_a = {1'b0, cmd.range_end};
      cmp_b = sum;
    end else begin
      cmp_a = addr;
      cmp_b = {1'b0, cmd.range_end};
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign full     = entry_total >= pftc_pkg::CNT_W'(pftc_pkg::TABLE_ENTRIES);
  assign idx_end  = (idx >= entry_total) || (idx >= pftc_pkg::CNT_W'(pftc_pkg::TABLE_ENTRIES));
  assign srch_hit = (cmd.range_start[PS-1:0] == '0) &&
                    (mem_rdata.frame == cmd.range_start[pftc_pkg::ADDR_W-1:PS]);
  assign clm_ok   = (addr[PS-1:0] == '0) &&
                    (mem_rdata.frame == addr[pftc_pkg::ADDR_W-1:PS]) &&
                    (mem_rdata.owner == pftc_pkg::OWN_FREE) &&
                    (mem_rdata.uses == '0) && !mem_rdata.alloc;
  assign want     = {1'b0, size[pftc_pkg::ADDR_W-1:PS]} +
                    (pftc_pkg::FRAME_W + 1)'(|size[PS-1:0]);

  always_comb begin
    state_next = state;
    unique case (state)
      pftc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (request.req_type)
            pftc_pkg::REQ_ADD:
              state_next = request.region_usable ? pftc_pkg::S_ADD_CHK : pftc_pkg::S_DONE;
            pftc_pkg::REQ_CLAIM: state_next = pftc_pkg::S_SRCH_RD;
            pftc_pkg::REQ_READ: begin
              if ({1'b0, request.entry_index} >= pftc_pkg::CNT_W'(pftc_pkg::TABLE_ENTRIES)) begin
                state_next = pftc_pkg::S_DONE;
              end else begin
                state_next = pftc_pkg::S_RD_OUT;
              end
            end
            default: state_next = pftc_pkg::S_DONE;
          endcase
        end
      end
      pftc_pkg::S_ADD_CHK: begin
        if (cmp_lt || full) begin
          state_next = pftc_pkg::S_DONE;
        end else begin
          state_next = pftc_pkg::S_ADD_WR;
        end
      end
      pftc_pkg::S_ADD_WR: state_next = pftc_pkg::S_ADD_CHK;
      pftc_pkg::S_SRCH_RD: begin
        state_next = idx_end ? pftc_pkg::S_DONE : pftc_pkg::S_SRCH_CMP;
      end
      pftc_pkg::S_SRCH_CMP: begin
        state_next = srch_hit ? pftc_pkg::S_CLM_CHK : pftc_pkg::S_SRCH_RD;
      end
      pftc_pkg::S_CLM_CHK: begin
        if (!cmp_lt) begin
          state_next = pftc_pkg::S_CLM_SIZE;
        end else if (idx_end) begin
          state_next = pftc_pkg::S_DONE;
        end else begin
          state_next = pftc_pkg::S_CLM_CMP;
        end
      end
      pftc_pkg::S_CLM_CMP: begin
        state_next = clm_ok ? pftc_pkg::S_CLM_CHK : pftc_pkg::S_DONE;
      end
      pftc_pkg::S_CLM_SIZE: state_next = pftc_pkg::S_CLM_FIN;
      pftc_pkg::S_CLM_FIN:  state_next = pftc_pkg::S_DONE;
      pftc_pkg::S_RD_OUT:   state_next = pftc_pkg::S_DONE;
      pftc_pkg::S_DONE:     state_next = pftc_pkg::S_IDLE;
      default:              state_next = pftc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != pftc_pkg::S_IDLE);
    done        = (state == pftc_pkg::S_DONE);
    rsp_load    = 1'b0;
    rsp_next    = '0;
    rsp_next.page_count = entry_total;
    rd_addr     = idx[pftc_pkg::IDX_W-1:0];
    mem_we      = 1'b0;
    mem_waddr   = idx[pftc_pkg::IDX_W-1:0];
    mem_wdata   = mem_rdata;
    idx_clr     = 1'b0;
    idx_inc     = 1'b0;
    addr_load   = 1'b0;
    addr_adv    = 1'b0;
    claimed_inc = 1'b0;
    total_inc   = 1'b0;
    size_load   = 1'b0;
    unique case (state)
      pftc_pkg::S_IDLE: begin
        rd_addr   = request.entry_index;
        addr_load = accept;
        idx_clr   = accept;
        if (accept) begin
          rsp_load = 1'b1;
          if (request.req_type == pftc_pkg::REQ_READ) begin
            rsp_next.status = pftc_pkg::ST_NOT_FOUND;
          end
        end
      end
      pftc_pkg::S_ADD_CHK: begin
        if (cmp_lt || full) begin
          rsp_load = 1'b1;
          rsp_next.status = cmp_lt ? pftc_pkg::ST_OK : pftc_pkg::ST_FULL;
        end
      end
      pftc_pkg::S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = entry_total[pftc_pkg::IDX_W-1:0];
        mem_wdata = '{frame: addr[pftc_pkg::ADDR_W-1:PS], owner: pftc_pkg::OWN_FREE,
                      uses: '0, alloc: 1'b0};
        total_inc = 1'b1;
        addr_adv  = 1'b1;
      end
      pftc_pkg::S_SRCH_RD: begin
        if (idx_end) begin
          rsp_load = 1'b1;
          rsp_next.status = pftc_pkg::ST_NOT_FOUND;
          rsp_next.page_count = '0;
        end
      end
      pftc_pkg::S_SRCH_CMP: begin
        idx_inc = !srch_hit;
      end
      pftc_pkg::S_CLM_CHK: begin
        if (cmp_lt && idx_end) begin
          rsp_load = 1'b1;
          rsp_next.status = pftc_pkg::ST_MISMATCH;
          rsp_next.page_count = '0;
        end
      end
      pftc_pkg::S_CLM_CMP: begin
        if (clm_ok) begin
          mem_we      = 1'b1;
          mem_wdata   = '{frame: mem_rdata.frame, owner: pftc_pkg::OWN_KERNEL,
                          uses: mem_rdata.uses + 8'd1, alloc: 1'b1};
          idx_inc     = 1'b1;
          claimed_inc = 1'b1;
          addr_adv    = 1'b1;
        end else begin
          rsp_load = 1'b1;
          rsp_next.status = pftc_pkg::ST_MISMATCH;
          rsp_next.page_count = '0;
        end
      end
      pftc_pkg::S_CLM_SIZE: size_load = 1'b1;
      pftc_pkg::S_CLM_FIN: begin
        rsp_load = 1'b1;
        if (want == (pftc_pkg::FRAME_W + 1)'(claimed)) begin
          rsp_next.status = pftc_pkg::ST_OK;
          rsp_next.page_count = claimed;
        end else begin
          rsp_next.status = pftc_pkg::ST_SIZE;
          rsp_next.page_count = '0;
        end
      end
      pftc_pkg::S_RD_OUT: begin
        rsp_load = 1'b1;
        rsp_next.frame_number = mem_rdata.frame;
        rsp_next.owner        = mem_rdata.owner;
        rsp_next.use_count    = mem_rdata.uses;
        rsp_next.allocated    = mem_rdata.alloc;
      end
      pftc_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pftc_pkg::S_IDLE;
      entry_total <= '0;
    end else begin
      state <= state_next;
      if (total_inc) begin
        entry_total <= entry_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request;
    end
    if (idx_clr) begin
      idx     <= '0;
      claimed <= '0;
    end else begin
      if (idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (claimed_inc) begin
        claimed <= claimed + 1'b1;
      end
    end
    if (addr_load) begin
      addr <= {1'b0, request.range_start};
    end else if (addr_adv) begin
      addr <= sum;
    end
    if (size_load) begin
      size <= cmd.range_end - cmd.range_start;
    end
    if (rsp_load) begin
      result <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[rd_addr];
  end

endmodule

### hw/rtl/pftc_checker.sv
// Port-level checker for the page frame table claim block, bound to the top level.
`include "page_frame_table_claim_top_assert.svh"

module pftc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input pftc_pkg::rsp_t result
);

  `PFTC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `PFTC_ASSERT_NOW(a_done_busy, clk, rst, done, busy)
  `PFTC_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  `PFTC_ASSERT_NOW(a_status_code, clk, rst, done, result.status <= pftc_pkg::ST_FULL)

endmodule

bind page_frame_table_claim_top pftc_checker u_pftc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
